// File: rtl/core/multiplexed_seven_segment_driver_core_macros.svh
// Assertion macros shared by the checker of the seven-segment driver core.
// Depends on nothing; included by the files that assert.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_CORE_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define MSSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define MSSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mssd_pkg.sv
// Package of the seven-segment driver core: widths, codes, digit decode
// and the divide-by-ten step. Depends on nothing.
package mssd_pkg;

    localparam int OP_W      = 1;
    localparam int VALUE_W   = 16;
    localparam int DIGIT_W   = 4;
    localparam int SEG_W     = 7;
    localparam int EN_W      = 3;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    // reciprocal of ten, exact for any 16-bit dividend
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP = 17'd52429;

    localparam logic [OP_W-1:0] OP_TICK = 1'b0;
    localparam logic [OP_W-1:0] OP_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK  = 1'b1;

    localparam logic [CFG_W-1:0] PERIOD_RESET = 8'd5;
    localparam logic [CFG_W-1:0] BLANK_RESET  = 8'd1;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic [VALUE_W-1:0] quo;
        digit_t             rem;
    } div10_t;

    // one decimal digit off the bottom of v
    function automatic div10_t div10(input logic [VALUE_W-1:0] v);
        logic [VALUE_W+RECIP_W-1:0] prod;
        logic [VALUE_W-1:0]         q;
        logic [VALUE_W-1:0]         back;
        div10_t                     r;
        prod  = (VALUE_W+RECIP_W)'(v) * (VALUE_W+RECIP_W)'(RECIP);
        q     = VALUE_W'(prod >> RECIP_SHIFT);
        back  = (q << 3) + (q << 1);
        r.quo = q;
        r.rem = DIGIT_W'(v - back);
        return r;
    endfunction

    // segment pattern, bit0 = a .. bit6 = g; codes above nine stay dark
    function automatic logic [SEG_W-1:0] seg_decode(input digit_t d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/mssd_cmd_if.sv
// Command channel of the seven-segment driver core: tick or load items.
// Depends on mssd_pkg.
interface mssd_cmd_if;
    import mssd_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;

    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

// File: rtl/core/mssd_drive_if.sv
// Drive channel of the seven-segment driver core: segment and common state.
// Depends on mssd_pkg.
interface mssd_drive_if;
    import mssd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segments;
    logic [EN_W-1:0]  digit_enable;

    modport source (output valid, segments, digit_enable, input ready);
    modport sink   (input valid, segments, digit_enable, output ready);
endinterface

// File: rtl/core/multiplexed_seven_segment_driver_core.sv
// Pipeline: an item's result is offered after it passes the input register,
// one divide-by-ten stage per digit and the drive register.
// Throughput: one item per cycle unless drive.ready stalls; each digit stage holds one constant multiply.
// Reset (rst_n, async, active low): display dark, digits zero, scan at digit 0,
// period 5 and blank time 1; the block takes items in the first cycle after it.
// Depends on mssd_pkg, mssd_cmd_if and mssd_drive_if.
module multiplexed_seven_segment_driver_core #(
    parameter int NUM_DIGITS = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mssd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mssd_pkg::CFG_W-1:0]         cfg_data,
    mssd_cmd_if.sink                           cmd,
    mssd_drive_if.source                       drive
);
    import mssd_pkg::*;

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

    // pipeline stage 0 is the input register, stage k has k digits done
    logic [NUM_DIGITS:0] vld_reg;
    logic [NUM_DIGITS:0] can;
    logic [OP_W-1:0]     op_reg  [0:NUM_DIGITS];
    logic [VALUE_W-1:0]  quo_reg [0:NUM_DIGITS-1];
    digit_t              dig_reg [0:NUM_DIGITS][0:NUM_DIGITS-1];
    div10_t              div_res [0:NUM_DIGITS-1];

    // configuration and display state
    logic [CFG_W-1:0]    period_reg;
    logic [CFG_W-1:0]    blank_reg;
    digit_t              store_reg [0:NUM_DIGITS-1];
    digit_t              store_next [0:NUM_DIGITS-1];
    logic [IDX_W-1:0]    scan_reg, scan_next;
    logic [CFG_W-1:0]    tick_reg, tick_next;
    logic                blanked_reg, blanked_next;
    logic [SEG_W-1:0]    seg_reg, seg_next;
    logic [EN_W-1:0]     en_reg, en_next;
    logic                out_vld_reg;

    logic                out_can;
    logic                fire;
    logic                light;
    logic [CFG_W-1:0]    per;

    // stall chain: a stage may load when empty or when it moves on
    always_comb
    begin
        out_can = !out_vld_reg || drive.ready;
        can[NUM_DIGITS] = !vld_reg[NUM_DIGITS] || out_can;
        for (int s = NUM_DIGITS - 1; s >= 0; s--)
        begin
            can[s] = !vld_reg[s] || can[s + 1];
        end
    end

    assign cmd.ready = can[0];
    assign fire      = vld_reg[NUM_DIGITS] && out_can;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (can[0])
        begin
            vld_reg[0] <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can[0])
        begin
            op_reg[0]  <= cmd.op;
            quo_reg[0] <= cmd.value;
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                dig_reg[0][k] <= '0;
            end
        end
    end

    // one divide-by-ten per stage, least significant digit first
    for (genvar g = 1; g <= NUM_DIGITS; g++)
    begin : g_stage
        assign div_res[g-1] = div10(quo_reg[g-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (can[g])
            begin
                vld_reg[g] <= vld_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (can[g])
            begin
                op_reg[g] <= op_reg[g-1];
                for (int k = 0; k < NUM_DIGITS; k++)
                begin
                    dig_reg[g][k] <= (k == NUM_DIGITS - g) ? div_res[g-1].rem
                                                           : dig_reg[g-1][k];
                end
            end
        end

        if (g < NUM_DIGITS)
        begin : g_quo
            always_ff @(posedge clk)
            begin
                if (can[g])
                begin
                    quo_reg[g] <= div_res[g-1].quo;
                end
            end
        end
    end

    // scanner and digit store update for the item leaving the last stage
    assign per = (period_reg == '0) ? CFG_W'(1) : period_reg;

    always_comb
    begin
        light        = 1'b0;
        store_next   = store_reg;
        scan_next    = scan_reg;
        tick_next    = tick_reg;
        blanked_next = blanked_reg;
        seg_next     = seg_reg;
        en_next      = en_reg;

        if (op_reg[NUM_DIGITS] == OP_LOAD)
        begin
            store_next = dig_reg[NUM_DIGITS];
        end
        else
        begin
            tick_next = (tick_reg == '1) ? tick_reg : tick_reg + 1'b1;
            if (!blanked_reg)
            begin
                if (tick_next >= per)
                begin
                    seg_next     = '0;
                    en_next      = '0;
                    tick_next    = '0;
                    blanked_next = 1'b1;
                    light        = (blank_reg == '0);
                end
            end
            else if (tick_next >= blank_reg)
            begin
                light = 1'b1;
            end
        end

        if (light)
        begin
            seg_next = seg_decode(store_reg[scan_reg]);
            for (int b = 0; b < EN_W; b++)
            begin
                en_next[b] = (int'(scan_reg) == b);
            end
            scan_next    = (scan_reg == LAST_IDX) ? '0 : scan_reg + 1'b1;
            blanked_next = 1'b0;
        end
    end

    // state, drive register and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RESET;
            blank_reg   <= BLANK_RESET;
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                store_reg[k] <= '0;
            end
            scan_reg    <= '0;
            tick_reg    <= '0;
            blanked_reg <= 1'b0;
            seg_reg     <= '0;
            en_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PERIOD: period_reg <= cfg_data;
                    CFG_BLANK:  blank_reg  <= cfg_data;
                    default:    ;
                endcase
            end

            if (fire)
            begin
                store_reg   <= store_next;
                scan_reg    <= scan_next;
                tick_reg    <= tick_next;
                blanked_reg <= blanked_next;
                seg_reg     <= seg_next;
                en_reg      <= en_next;
                out_vld_reg <= 1'b1;
            end
            else if (drive.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign drive.valid        = out_vld_reg;
    assign drive.segments     = seg_reg;
    assign drive.digit_enable = en_reg;

endmodule

// File: rtl/core/mssd_checker.sv
// Port-level checks of the seven-segment driver core, bound to the driver core module.
// Depends on mssd_pkg and the assertion macro header.
`include "multiplexed_seven_segment_driver_core_macros.svh"

module mssd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         drive_valid,
    input logic                         drive_ready,
    input logic [mssd_pkg::SEG_W-1:0]   segments,
    input logic [mssd_pkg::EN_W-1:0]    digit_enable
);
    import mssd_pkg::*;

    // at most one common is driven
    `MSSD_ASSERT_IMPL(a_one_common, clk, rst_n, drive_valid, $onehot0(digit_enable), "two commons lit")

    // a lit common always carries a digit pattern
    `MSSD_ASSERT_IMPL(a_lit_has_segs, clk, rst_n, drive_valid && (digit_enable != '0), segments != '0, "common lit with dark segments")

    // a stalled item holds
    `MSSD_ASSERT_NEXT(a_stall_hold, clk, rst_n, drive_valid && !drive_ready, drive_valid && $stable(segments) && $stable(digit_enable), "stalled item changed")

    // nothing is offered right out of reset
    `MSSD_ASSERT_IMPL(a_reset_empty, clk, rst_n, $rose(rst_n), !drive_valid, "item offered after reset")

endmodule

bind multiplexed_seven_segment_driver_core mssd_checker u_mssd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .drive_valid  (drive.valid),
    .drive_ready  (drive.ready),
    .segments     (drive.segments),
    .digit_enable (drive.digit_enable)
);
